>>> sv/scd_pkg.sv
package scd_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int NCH         = 8;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int COEF_W      = 32;
  localparam int SIDE_W      = SAMPLE_BITS + 2;
  localparam int PM_W        = SAMPLE_BITS + COEF_W;
  localparam int PS_W        = SIDE_W + COEF_W;
  localparam int ACC_W       = PS_W + 1;
  localparam int SHIFT_STEREO = 30;
  localparam int SHIFT_MONO   = 31;
  localparam int STAGES       = 4;
  localparam int FLIGHT_W     = $clog2(STAGES + 1);

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IN_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COUNT = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] CNT_MONO   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_STEREO = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_5_1    = CNT_W'(6);
  localparam logic [CNT_W-1:0] CNT_7_1    = CNT_W'(8);
  localparam logic [CNT_W-1:0] CNT_RESET  = CNT_W'(2);

  // Q30 mixing coefficients
  localparam logic signed [COEF_W-1:0] COEF_UNITY = 32'sd1073741824;
  localparam logic signed [COEF_W-1:0] N6_MAIN    = 32'sd444758426;
  localparam logic signed [COEF_W-1:0] N6_SIDE    = 32'sd314491699;
  localparam logic signed [COEF_W-1:0] N8_MAIN    = 32'sd344002444;
  localparam logic signed [COEF_W-1:0] N8_SIDE    = 32'sd243246460;

  localparam logic signed [ACC_W-1:0] BIAS_STEREO = ACC_W'(64'sd536870912);
  localparam logic signed [ACC_W-1:0] BIAS_MONO   = ACC_W'(64'sd1073741824);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [NCH-1:0][SAMPLE_BITS-1:0] frame_t;

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_PASS,
    MODE_AVG,
    MODE_DMX
  } mode_t;

  typedef struct packed {
    logic dmx;
    logic mono;
    logic last;
  } ctrl_t;

endpackage

>>> sv/surround_channel_downmix_core.sv
// Throughput: one frame per cycle while the output is taken; out_ready low stalls the
// four register stages (decode, multiply, accumulate, round and saturate), each of which
// holds one frame and advances only when the stage after it can take the frame.
// Reset (rst, synchronous, active high): empties every stage and sets both channel
// counts to 2; sample registers keep whatever they held.
module surround_channel_downmix_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [scd_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [scd_pkg::CNT_W-1:0]              cfg_data,
  // input frame channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_ch0,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_ch1,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_ch2,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_ch3,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_ch4,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_ch5,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_ch6,
  input  logic signed [scd_pkg::SAMPLE_BITS-1:0] in_ch7,
  input  logic                                   in_last,
  // output frame channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_ch0,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_ch1,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_ch2,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_ch3,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_ch4,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_ch5,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_ch6,
  output logic signed [scd_pkg::SAMPLE_BITS-1:0] out_ch7,
  output logic                                   out_last
);

  // channel count registers
  logic [scd_pkg::CNT_W-1:0] in_count;
  logic [scd_pkg::CNT_W-1:0] out_count;

  scd_pkg::frame_t in_frame;
  scd_pkg::frame_t out_frame;

  // stage 1 -> stage 2
  logic                                   dec_valid;
  logic                                   mul_ready;
  scd_pkg::ctrl_t                         dec_ctrl;
  scd_pkg::frame_t                        dec_direct;
  scd_pkg::sample_t                       dec_main_l;
  scd_pkg::sample_t                       dec_main_r;
  logic signed [scd_pkg::SIDE_W-1:0]      dec_side_l;
  logic signed [scd_pkg::SIDE_W-1:0]      dec_side_r;
  logic signed [scd_pkg::COEF_W-1:0]      dec_coef_main;
  logic signed [scd_pkg::COEF_W-1:0]      dec_coef_side;

  // stage 2 -> stage 3
  logic                                   mul_valid;
  logic                                   acc_ready;
  scd_pkg::ctrl_t                         mul_ctrl;
  scd_pkg::frame_t                        mul_direct;
  logic signed [scd_pkg::PM_W-1:0]        mul_ml;
  logic signed [scd_pkg::PM_W-1:0]        mul_mr;
  logic signed [scd_pkg::PS_W-1:0]        mul_sl;
  logic signed [scd_pkg::PS_W-1:0]        mul_sr;

  // stage 3 -> stage 4
  logic                                   acc_valid;
  logic                                   rnd_ready;
  scd_pkg::ctrl_t                         acc_ctrl;
  scd_pkg::frame_t                        acc_direct;
  logic signed [scd_pkg::ACC_W-1:0]       acc_l;
  logic signed [scd_pkg::ACC_W-1:0]       acc_r;

  // frames in flight, for checking only
  logic [scd_pkg::FLIGHT_W-1:0]           inflight;
  logic [scd_pkg::FLIGHT_W-1:0]           inflight_next;

  // Configuration is always taken; writes to an unknown index are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_count  <= scd_pkg::CNT_RESET;
      out_count <= scd_pkg::CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        scd_pkg::REG_IN_COUNT:  in_count  <= cfg_data;
        scd_pkg::REG_OUT_COUNT: out_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // gather the sample ports into one frame
  assign in_frame[0] = in_ch0;
  assign in_frame[1] = in_ch1;
  assign in_frame[2] = in_ch2;
  assign in_frame[3] = in_ch3;
  assign in_frame[4] = in_ch4;
  assign in_frame[5] = in_ch5;
  assign in_frame[6] = in_ch6;
  assign in_frame[7] = in_ch7;

  // Stage 1: work out the mode, build pass-through and averaged channels,
  // pre-add centre and surrounds, and pick the coefficients.
  scd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_frame  (in_frame),
    .in_last   (in_last),
    .in_count  (in_count),
    .out_count (out_count),
    .out_valid (dec_valid),
    .out_ready (mul_ready),
    .ctrl      (dec_ctrl),
    .direct    (dec_direct),
    .main_l    (dec_main_l),
    .main_r    (dec_main_r),
    .side_l    (dec_side_l),
    .side_r    (dec_side_r),
    .coef_main (dec_coef_main),
    .coef_side (dec_coef_side)
  );

  // Stage 2: four Q30 coefficient products.
  scd_mult u_mult (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dec_valid),
    .in_ready   (mul_ready),
    .in_ctrl    (dec_ctrl),
    .in_direct  (dec_direct),
    .main_l     (dec_main_l),
    .main_r     (dec_main_r),
    .side_l     (dec_side_l),
    .side_r     (dec_side_r),
    .coef_main  (dec_coef_main),
    .coef_side  (dec_coef_side),
    .out_valid  (mul_valid),
    .out_ready  (acc_ready),
    .out_ctrl   (mul_ctrl),
    .out_direct (mul_direct),
    .prod_ml    (mul_ml),
    .prod_mr    (mul_mr),
    .prod_sl    (mul_sl),
    .prod_sr    (mul_sr)
  );

  // Stage 3: left and right sums with the rounding offset added in.
  scd_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (mul_valid),
    .in_ready   (acc_ready),
    .in_ctrl    (mul_ctrl),
    .in_direct  (mul_direct),
    .prod_ml    (mul_ml),
    .prod_mr    (mul_mr),
    .prod_sl    (mul_sl),
    .prod_sr    (mul_sr),
    .out_valid  (acc_valid),
    .out_ready  (rnd_ready),
    .out_ctrl   (acc_ctrl),
    .out_direct (acc_direct),
    .acc_l      (acc_l),
    .acc_r      (acc_r)
  );

  // Stage 4: floor shift, saturate, and hold the result for the output transfer.
  scd_round u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (acc_valid),
    .in_ready  (rnd_ready),
    .in_ctrl   (acc_ctrl),
    .in_direct (acc_direct),
    .acc_l     (acc_l),
    .acc_r     (acc_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_frame (out_frame),
    .out_last  (out_last)
  );

  // spread the result frame over the sample ports
  assign out_ch0 = out_frame[0];
  assign out_ch1 = out_frame[1];
  assign out_ch2 = out_frame[2];
  assign out_ch3 = out_frame[3];
  assign out_ch4 = out_frame[4];
  assign out_ch5 = out_frame[5];
  assign out_ch6 = out_frame[6];
  assign out_ch7 = out_frame[7];

  // count frames between input and output transfers
  always_comb begin
    inflight_next = inflight;
    if (in_valid && in_ready) inflight_next = inflight_next + scd_pkg::FLIGHT_W'(1);
    if (out_valid && out_ready) inflight_next = inflight_next - scd_pkg::FLIGHT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight_next;
    end
  end

  // the pipeline can only refuse input when every stage, the last included, is full
  a_block_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && inflight == scd_pkg::FLIGHT_W'(scd_pkg::STAGES)))
    else $error("input stalled with room in the pipeline");

  // never more frames held than there are stages
  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    inflight <= scd_pkg::FLIGHT_W'(scd_pkg::STAGES))
    else $error("more frames in flight than stages");

  // a result offered means a frame was taken and not yet delivered
  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inflight != '0))
    else $error("result offered with no frame in flight");

  // reset empties the output stage
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

>>> sv/scd_decode.sv
module scd_decode (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  scd_pkg::frame_t                       in_frame,
  input  logic                                  in_last,
  input  logic [scd_pkg::CNT_W-1:0]             in_count,
  input  logic [scd_pkg::CNT_W-1:0]             out_count,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output scd_pkg::ctrl_t                        ctrl,
  output scd_pkg::frame_t                       direct,
  output scd_pkg::sample_t                      main_l,
  output scd_pkg::sample_t                      main_r,
  output logic signed [scd_pkg::SIDE_W-1:0]     side_l,
  output logic signed [scd_pkg::SIDE_W-1:0]     side_r,
  output logic signed [scd_pkg::COEF_W-1:0]     coef_main,
  output logic signed [scd_pkg::COEF_W-1:0]     coef_side
);

  scd_pkg::mode_t                          mode;
  scd_pkg::frame_t                         direct_next;
  logic signed [scd_pkg::SIDE_W-1:0]       side_l_next;
  logic signed [scd_pkg::SIDE_W-1:0]       side_r_next;
  logic signed [scd_pkg::COEF_W-1:0]       coef_main_next;
  logic signed [scd_pkg::COEF_W-1:0]       coef_side_next;
  logic signed [scd_pkg::SAMPLE_BITS:0]    avg_l;
  logic signed [scd_pkg::SAMPLE_BITS:0]    avg_r;
  logic                                    stereo_in;
  logic                                    stereo_out;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    stereo_in  = (in_count == scd_pkg::CNT_STEREO) || (in_count == scd_pkg::CNT_5_1) ||
                 (in_count == scd_pkg::CNT_7_1);
    stereo_out = (out_count == scd_pkg::CNT_MONO) || (out_count == scd_pkg::CNT_STEREO);
    if (in_count == out_count) begin
      mode = scd_pkg::MODE_PASS;
    end else if (in_count == scd_pkg::CNT_7_1 && out_count == scd_pkg::CNT_5_1) begin
      mode = scd_pkg::MODE_AVG;
    end else if (stereo_in && stereo_out) begin
      mode = scd_pkg::MODE_DMX;
    end else begin
      mode = scd_pkg::MODE_ZERO;
    end
  end

  // rear pair averages for 7.1 into 5.1, rounding half up
  always_comb begin
    avg_l = $signed({in_frame[4][scd_pkg::SAMPLE_BITS-1], in_frame[4]}) +
            $signed({in_frame[6][scd_pkg::SAMPLE_BITS-1], in_frame[6]}) +
            (scd_pkg::SAMPLE_BITS+1)'(1);
    avg_r = $signed({in_frame[5][scd_pkg::SAMPLE_BITS-1], in_frame[5]}) +
            $signed({in_frame[7][scd_pkg::SAMPLE_BITS-1], in_frame[7]}) +
            (scd_pkg::SAMPLE_BITS+1)'(1);
  end

  always_comb begin
    for (int i = 0; i < scd_pkg::NCH; i++) begin
      direct_next[i] = '0;
      case (mode)
        scd_pkg::MODE_PASS: begin
          if (scd_pkg::CNT_W'(i) < in_count) direct_next[i] = in_frame[i];
        end
        scd_pkg::MODE_AVG: begin
          if (i < 4) direct_next[i] = in_frame[i];
          else if (i == 4) direct_next[i] = avg_l[scd_pkg::SAMPLE_BITS:1];
          else if (i == 5) direct_next[i] = avg_r[scd_pkg::SAMPLE_BITS:1];
        end
        default: direct_next[i] = '0;
      endcase
    end
  end

  always_comb begin
    side_l_next = scd_pkg::SIDE_W'($signed(in_frame[2])) +
                  scd_pkg::SIDE_W'($signed(in_frame[4]));
    side_r_next = scd_pkg::SIDE_W'($signed(in_frame[2])) +
                  scd_pkg::SIDE_W'($signed(in_frame[5]));
    case (in_count)
      scd_pkg::CNT_5_1: begin
        coef_main_next = scd_pkg::N6_MAIN;
        coef_side_next = scd_pkg::N6_SIDE;
      end
      scd_pkg::CNT_7_1: begin
        coef_main_next = scd_pkg::N8_MAIN;
        coef_side_next = scd_pkg::N8_SIDE;
        side_l_next    = side_l_next + scd_pkg::SIDE_W'($signed(in_frame[6]));
        side_r_next    = side_r_next + scd_pkg::SIDE_W'($signed(in_frame[7]));
      end
      default: begin
        coef_main_next = scd_pkg::COEF_UNITY;
        coef_side_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ctrl.dmx  <= (mode == scd_pkg::MODE_DMX);
      ctrl.mono <= (out_count == scd_pkg::CNT_MONO);
      ctrl.last <= in_last;
      direct    <= direct_next;
      main_l    <= in_frame[0];
      main_r    <= in_frame[1];
      side_l    <= side_l_next;
      side_r    <= side_r_next;
      coef_main <= coef_main_next;
      coef_side <= coef_side_next;
    end
  end

endmodule

>>> sv/scd_mult.sv
module scd_mult (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  scd_pkg::ctrl_t                        in_ctrl,
  input  scd_pkg::frame_t                       in_direct,
  input  scd_pkg::sample_t                      main_l,
  input  scd_pkg::sample_t                      main_r,
  input  logic signed [scd_pkg::SIDE_W-1:0]     side_l,
  input  logic signed [scd_pkg::SIDE_W-1:0]     side_r,
  input  logic signed [scd_pkg::COEF_W-1:0]     coef_main,
  input  logic signed [scd_pkg::COEF_W-1:0]     coef_side,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output scd_pkg::ctrl_t                        out_ctrl,
  output scd_pkg::frame_t                       out_direct,
  output logic signed [scd_pkg::PM_W-1:0]       prod_ml,
  output logic signed [scd_pkg::PM_W-1:0]       prod_mr,
  output logic signed [scd_pkg::PS_W-1:0]       prod_sl,
  output logic signed [scd_pkg::PS_W-1:0]       prod_sr
);

  logic signed [scd_pkg::PM_W-1:0] prod_ml_next;
  logic signed [scd_pkg::PM_W-1:0] prod_mr_next;
  logic signed [scd_pkg::PS_W-1:0] prod_sl_next;
  logic signed [scd_pkg::PS_W-1:0] prod_sr_next;

  assign in_ready     = !out_valid || out_ready;
  assign prod_ml_next = main_l * coef_main;
  assign prod_mr_next = main_r * coef_main;
  assign prod_sl_next = side_l * coef_side;
  assign prod_sr_next = side_r * coef_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_ctrl   <= in_ctrl;
      out_direct <= in_direct;
      prod_ml    <= prod_ml_next;
      prod_mr    <= prod_mr_next;
      prod_sl    <= prod_sl_next;
      prod_sr    <= prod_sr_next;
    end
  end

endmodule

>>> sv/scd_accum.sv
module scd_accum (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  scd_pkg::ctrl_t                        in_ctrl,
  input  scd_pkg::frame_t                       in_direct,
  input  logic signed [scd_pkg::PM_W-1:0]       prod_ml,
  input  logic signed [scd_pkg::PM_W-1:0]       prod_mr,
  input  logic signed [scd_pkg::PS_W-1:0]       prod_sl,
  input  logic signed [scd_pkg::PS_W-1:0]       prod_sr,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output scd_pkg::ctrl_t                        out_ctrl,
  output scd_pkg::frame_t                       out_direct,
  output logic signed [scd_pkg::ACC_W-1:0]      acc_l,
  output logic signed [scd_pkg::ACC_W-1:0]      acc_r
);

  logic signed [scd_pkg::ACC_W-1:0] bias_l;
  logic signed [scd_pkg::ACC_W-1:0] bias_r;
  logic signed [scd_pkg::ACC_W-1:0] acc_l_next;
  logic signed [scd_pkg::ACC_W-1:0] acc_r_next;

  assign in_ready = !out_valid || out_ready;

  // mono folds its whole rounding offset into the left sum
  assign bias_l = in_ctrl.mono ? scd_pkg::BIAS_MONO : scd_pkg::BIAS_STEREO;
  assign bias_r = in_ctrl.mono ? '0 : scd_pkg::BIAS_STEREO;

  assign acc_l_next = scd_pkg::ACC_W'(prod_ml) + scd_pkg::ACC_W'(prod_sl) + bias_l;
  assign acc_r_next = scd_pkg::ACC_W'(prod_mr) + scd_pkg::ACC_W'(prod_sr) + bias_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_ctrl   <= in_ctrl;
      out_direct <= in_direct;
      acc_l      <= acc_l_next;
      acc_r      <= acc_r_next;
    end
  end

endmodule

>>> sv/scd_round.sv
module scd_round (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  scd_pkg::ctrl_t                        in_ctrl,
  input  scd_pkg::frame_t                       in_direct,
  input  logic signed [scd_pkg::ACC_W-1:0]      acc_l,
  input  logic signed [scd_pkg::ACC_W-1:0]      acc_r,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output scd_pkg::frame_t                       out_frame,
  output logic                                  out_last
);

  logic signed [scd_pkg::ACC_W:0]   sum_m;
  logic signed [scd_pkg::ACC_W:0]   shl;
  logic signed [scd_pkg::ACC_W:0]   shr;
  logic signed [scd_pkg::ACC_W:0]   shm;
  scd_pkg::frame_t                  frame_next;

  function automatic scd_pkg::sample_t sat(input logic signed [scd_pkg::ACC_W:0] v);
    scd_pkg::sample_t r;
    if (v > scd_pkg::SAMPLE_MAX) r = scd_pkg::SAMPLE_MAX;
    else if (v < scd_pkg::SAMPLE_MIN) r = scd_pkg::SAMPLE_MIN;
    else r = v[scd_pkg::SAMPLE_BITS-1:0];
    return r;
  endfunction

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    sum_m = (scd_pkg::ACC_W+1)'(acc_l) + (scd_pkg::ACC_W+1)'(acc_r);
    shl   = (scd_pkg::ACC_W+1)'(acc_l) >>> scd_pkg::SHIFT_STEREO;
    shr   = (scd_pkg::ACC_W+1)'(acc_r) >>> scd_pkg::SHIFT_STEREO;
    shm   = sum_m >>> scd_pkg::SHIFT_MONO;
    frame_next = in_direct;
    if (in_ctrl.dmx) begin
      if (in_ctrl.mono) begin
        frame_next[0] = sat(shm);
        frame_next[1] = '0;
      end else begin
        frame_next[0] = sat(shl);
        frame_next[1] = sat(shr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_frame <= frame_next;
      out_last  <= in_ctrl.last;
    end
  end

endmodule
